FILE: rtl/lcw_pkg.sv
// ----------------------------------------------------------------------------
// lcw_pkg
// shared types and constants for the format80 decompressor
// ----------------------------------------------------------------------------
package lcw_pkg;

    localparam int unsigned LCW_OUT_DEPTH = 65536;
    localparam int unsigned LCW_QDEPTH    = 2;

    typedef struct packed {
        logic        operation;
        logic        first;
        logic [7:0]  data_byte;
        logic [15:0] read_addr;
    } t_lcw_in;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [16:0] produced;
        logic [1:0]  status;
    } t_lcw_out;

    localparam logic [0:0] OP_PUSH = 1'b0;
    localparam logic [0:0] OP_READ = 1'b1;

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_LEN = 2'd1;
    localparam logic [1:0] ST_END = 2'd2;
    localparam logic [1:0] ST_BAD = 2'd3;

    typedef enum logic [2:0] {
        PH_FIRST, PH_CMD, PH_LIT, PH_CNT_LO, PH_CNT_HI, PH_FILLVAL, PH_POS_LO, PH_POS_HI
    } t_phase;

    // back-end job kinds
    typedef enum logic [2:0] {
        JB_NONE, JB_READ, JB_LIT, JB_FILL, JB_COPY
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [15:0] addr;
        logic [7:0]  value;
        logic [16:0] count;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE, BK_RD, BK_RDWAIT, BK_CPRD, BK_CPWR, BK_OUT
    } t_bstate;

endpackage

FILE: rtl/lcw_front.sv
// ----------------------------------------------------------------------------
// lcw_front
// command parser: tracks stream state and issues jobs to the back end
// ----------------------------------------------------------------------------
module lcw_front import lcw_pkg::*; #(
    parameter int unsigned OUT_DEPTH = LCW_OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [16:0] i_out_length,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_lcw_in     i_item,
    output logic        o_job_valid,
    input  logic        i_job_stall,
    output t_job        o_job,
    output logic [16:0] o_wp,
    output logic [1:0]  o_status
);

    localparam logic [16:0] DepthW = 17'(OUT_DEPTH);

    logic [16:0] r_wp, n_wp;
    logic        r_rel, n_rel;
    t_phase      r_ph, n_ph;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_cnt, n_cnt;
    logic [7:0]  r_slo, n_slo;
    logic [1:0]  r_st, n_st;
    logic [16:0] eff, room, clipped;
    logic [15:0] cnt_in;
    logic [16:0] pos, from;
    logic        rel_m;
    logic        go;
    t_job        job;

    assign o_stall     = i_job_stall;
    assign go          = i_valid && !i_job_stall;
    assign o_job_valid = go;
    assign o_job       = job;
    assign o_wp        = n_wp;
    assign o_status    = n_st;

    assign eff  = (i_out_length > DepthW) ? DepthW : i_out_length;

    always_comb begin
        logic [16:0] wp0;
        logic [1:0]  st0;
        wp0   = i_item.first ? 17'd0 : r_wp;
        st0   = i_item.first ? ST_RUN : r_st;
        n_wp  = r_wp;
        n_rel = r_rel;
        n_ph  = r_ph;
        n_cmd = r_cmd;
        n_cnt = r_cnt;
        n_slo = r_slo;
        n_st  = r_st;
        room  = (wp0 < eff) ? (eff - wp0) : 17'd0;
        cnt_in = 16'd0;
        pos   = 17'd0;
        rel_m = 1'b0;
        from  = 17'd0;
        clipped = 17'd0;
        job.kind  = JB_NONE;
        job.addr  = i_item.read_addr;
        job.value = i_item.data_byte;
        job.count = 17'd0;
        if (i_item.operation == OP_READ) begin
            job.kind = JB_READ;
        end else begin
            if (i_item.first) begin
                n_wp = 17'd0; n_rel = 1'b0; n_ph = PH_FIRST; n_cmd = 8'd0;
                n_cnt = 16'd0; n_slo = 8'd0; n_st = ST_RUN;
            end
            if (st0 != ST_RUN) begin
            end else if (wp0 >= eff) begin
                n_st = ST_LEN;
            end else begin
                // classify
                unique case (r_ph == PH_FIRST && !i_item.first ? PH_FIRST :
                             (i_item.first ? PH_FIRST : r_ph))
                    PH_FIRST, PH_CMD: begin
                        if ((i_item.first || r_ph == PH_FIRST) && i_item.data_byte == 8'd0) begin
                            n_rel = 1'b1;
                            n_ph  = PH_CMD;
                        end else begin
                            if (i_item.first || r_ph == PH_FIRST) n_rel = 1'b0;
                            n_cmd = i_item.data_byte;
                            if (!i_item.data_byte[7]) begin
                                n_ph = PH_POS_LO;
                            end else if (!i_item.data_byte[6]) begin
                                if (i_item.data_byte[5:0] == 6'd0) begin
                                    n_st = ST_END;
                                end else begin
                                    n_cnt = {10'd0, i_item.data_byte[5:0]};
                                    n_ph  = PH_LIT;
                                end
                            end else if (i_item.data_byte[7:1] == 7'h7F) begin
                                n_ph = PH_CNT_LO;
                            end else begin
                                n_ph = PH_POS_LO;
                            end
                        end
                    end
                    PH_LIT: begin
                        job.kind  = JB_LIT;
                        job.addr  = wp0[15:0];
                        job.count = 17'd1;
                        n_wp  = wp0 + ((wp0 < DepthW) ? 17'd1 : 17'd0);
                        n_cnt = r_cnt - 16'd1;
                        if (n_cnt == 16'd0) begin
                            n_ph = PH_CMD;
                            if (n_wp >= eff) n_st = ST_LEN;
                        end else if (n_wp >= eff) begin
                            n_st = ST_LEN;
                        end
                    end
                    PH_CNT_LO: begin
                        n_cnt = {8'd0, i_item.data_byte};
                        n_ph  = PH_CNT_HI;
                    end
                    PH_CNT_HI: begin
                        n_cnt = {i_item.data_byte, r_cnt[7:0]};
                        n_ph  = (r_cmd == 8'hFE) ? PH_FILLVAL : PH_POS_LO;
                    end
                    PH_FILLVAL: begin
                        clipped   = ({1'b0, r_cnt} > room) ? room : {1'b0, r_cnt};
                        job.kind  = JB_FILL;
                        job.addr  = wp0[15:0];
                        job.count = clipped;
                        n_wp = wp0 + clipped;
                        n_ph = PH_CMD;
                        if (n_wp >= eff) n_st = ST_LEN;
                    end
                    default: begin
                        if (r_ph == PH_POS_LO && r_cmd[7]) begin
                            n_slo = i_item.data_byte;
                            n_ph  = PH_POS_HI;
                        end else begin
                            if (r_ph == PH_POS_LO) begin
                                pos    = {5'd0, r_cmd[3:0], i_item.data_byte};
                                rel_m  = 1'b1;
                                cnt_in = {13'd0, r_cmd[6:4]} + 16'd3;
                            end else begin
                                pos    = {1'b0, i_item.data_byte, r_slo};
                                rel_m  = r_rel;
                                cnt_in = (r_cmd == 8'hFF) ? r_cnt
                                                          : ({10'd0, r_cmd[5:0]} + 16'd3);
                            end
                            if (rel_m ? (pos > wp0) : (pos >= wp0)) begin
                                n_st = ST_BAD;
                            end else begin
                                from      = rel_m ? (wp0 - pos) : pos;
                                clipped   = ({1'b0, cnt_in} > room) ? room : {1'b0, cnt_in};
                                job.kind  = JB_COPY;
                                job.addr  = from[15:0];
                                job.value = 8'd0;
                                job.count = clipped;
                                n_wp = wp0 + clipped;
                                n_ph = PH_CMD;
                                if (n_wp >= eff) n_st = ST_LEN;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rel <= 1'b0; r_ph <= PH_FIRST; r_cmd <= '0;
            r_cnt <= '0; r_slo <= '0; r_st <= ST_RUN;
        end else if (go && i_item.operation == OP_PUSH) begin
            r_wp <= n_wp; r_rel <= n_rel; r_ph <= n_ph; r_cmd <= n_cmd;
            r_cnt <= n_cnt; r_slo <= n_slo; r_st <= n_st;
        end
    end

endmodule

FILE: rtl/lcw_queue.sv
// ----------------------------------------------------------------------------
// lcw_queue
// short job queue between parser and store engine
// ----------------------------------------------------------------------------
module lcw_queue import lcw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_job        i_job,
    input  logic [16:0] i_wp,
    input  logic [1:0]  i_status,
    output logic        o_valid,
    input  logic        i_pop,
    output t_job        o_job,
    output logic [16:0] o_wp,
    output logic [1:0]  o_status
);

    typedef struct packed {
        t_job        job;
        logic [16:0] wp;
        logic [1:0]  st;
    } t_qent;

    t_qent      r_mem [LCW_QDEPTH];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_stall  = (r_cnt == 2'(LCW_QDEPTH));
    assign push     = i_valid && !o_stall;
    assign o_valid  = (r_cnt != 2'd0);
    assign pop      = i_pop && o_valid;
    assign o_job    = r_mem[r_rd].job;
    assign o_wp     = r_mem[r_rd].wp;
    assign o_status = r_mem[r_rd].st;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= '{job: i_job, wp: i_wp, st: i_status};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0; r_rd <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: rtl/lcw_back.sv
// ----------------------------------------------------------------------------
// lcw_back
// store engine: writes, copies and reads the output store, emits results
// ----------------------------------------------------------------------------
module lcw_back import lcw_pkg::*; #(
    parameter int unsigned OUT_DEPTH = LCW_OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_pop,
    input  t_job        i_job,
    input  logic [16:0] i_wp,
    input  logic [1:0]  i_status,
    output logic        o_valid,
    input  logic        i_stall,
    output t_lcw_out    o_item
);

    localparam int unsigned AW = $clog2(OUT_DEPTH);

    logic [7:0]  r_mem [OUT_DEPTH];
    logic [7:0]  r_rdata;
    t_bstate     r_state, n_state;
    t_job        r_job, n_job;
    logic [16:0] r_base, n_base;   // write position / read address
    logic [16:0] r_lim, n_lim;     // literal and fill write position, read limit
    logic [16:0] r_wpo, n_wpo;
    logic [1:0]  r_sto, n_sto;
    logic [7:0]  r_od, n_od;
    logic        r_odsel, n_odsel;
    logic        we, re;
    logic [AW-1:0] wa, ra;
    logic [7:0]  wd;
    logic [16:0] src;

    assign o_valid = (r_state == BK_OUT);
    assign o_item.read_data = r_odsel ? r_rdata : r_od;
    assign o_item.produced  = r_wpo;
    assign o_item.status    = r_sto;

    always_comb begin
        n_state = r_state; n_job = r_job; n_base = r_base; n_lim = r_lim;
        n_wpo = r_wpo; n_sto = r_sto; n_od = r_od; n_odsel = r_odsel;
        o_pop = 1'b0; we = 1'b0; re = 1'b0;
        wa = r_base[AW-1:0]; ra = r_job.addr[AW-1:0]; wd = r_job.value;
        src = {1'b0, r_job.addr};
        unique case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_job = i_job; n_wpo = i_wp; n_sto = i_status;
                    n_od = 8'd0; n_odsel = 1'b0;
                    n_base = {1'b0, i_job.addr};
                    n_lim  = {1'b0, i_job.addr};
                    unique case (i_job.kind)
                        JB_READ: begin
                            n_state = BK_RD;
                            n_lim = r_wpo;
                        end
                        JB_LIT, JB_FILL: begin
                            n_state = (i_job.count == 17'd0) ? BK_OUT : BK_CPWR;
                            n_lim   = i_wp - i_job.count;
                        end
                        JB_COPY: begin
                            n_state = (i_job.count == 17'd0) ? BK_OUT : BK_CPRD;
                            n_base  = i_wp - i_job.count;
                            n_lim   = i_wp - i_job.count;
                        end
                        default: n_state = BK_OUT;
                    endcase
                end
            end
            BK_RD: begin
                re = 1'b1; ra = r_job.addr[AW-1:0];
                n_odsel = ({1'b0, r_job.addr} < r_lim);
                n_state = BK_RDWAIT;
            end
            BK_RDWAIT: n_state = BK_OUT;
            BK_CPRD: begin
                // read source; positions at or past the current write point read zero
                re = 1'b1; ra = r_job.addr[AW-1:0];
                n_state = BK_CPWR;
            end
            BK_CPWR: begin
                if (r_job.kind == JB_COPY) begin
                    src = {1'b0, r_job.addr};
                    wd  = (src < r_base) ? r_rdata : 8'd0;
                end else begin
                    wd = r_job.value;
                end
                we = 1'b1; wa = (r_job.kind == JB_COPY) ? r_base[AW-1:0] : r_lim[AW-1:0];
                n_job.count = r_job.count - 17'd1;
                n_job.addr  = r_job.addr + 16'd1;
                if (r_job.kind == JB_COPY) n_base = r_base + 17'd1;
                else n_lim = r_lim + 17'd1;
                if (r_job.count == 17'd1) n_state = BK_OUT;
                else if (r_job.kind == JB_COPY) n_state = BK_CPRD;
            end
            BK_OUT: if (!i_stall) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (re) r_rdata <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job; r_base <= n_base; r_lim <= n_lim;
        r_sto <= n_sto; r_od <= n_od; r_odsel <= n_odsel;
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_wpo   <= '0;
        end else begin
            r_state <= n_state;
            r_wpo   <= n_wpo;
        end
    end

endmodule

FILE: rtl/lcw_format80_decompressor_top.sv
// input beats pass through the parser front and the job queue to the store engine; the front
// takes a new beat while the queue has room, before the back has finished the last job
// a fill writes its bytes one store step at a time; a copy reads and then writes each byte
// reset: synchronous active low; stream state cleared, out_length set to 65536;
// the output store is not cleared
// ----------------------------------------------------------------------------
// lcw_format80_decompressor_top
// format80 decompressor: parser front, job queue, store engine back
// ----------------------------------------------------------------------------
module lcw_format80_decompressor_top import lcw_pkg::*; #(
    parameter int unsigned OUT_DEPTH = LCW_OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_lcw_in     i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_lcw_out    o_item
);

    logic [16:0] r_out_length;
    logic        f_valid, q_stall, q_valid, pop;
    t_job        f_job, q_job;
    logic [16:0] f_wp, q_wp;
    logic [1:0]  f_st, q_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_length <= 17'h10000;
        else if (i_cfg_we) r_out_length <= i_cfg_data;
    end

    lcw_front #(.OUT_DEPTH(OUT_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_out_length(r_out_length),
        .i_valid, .o_stall, .i_item,
        .o_job_valid(f_valid), .i_job_stall(q_stall), .o_job(f_job),
        .o_wp(f_wp), .o_status(f_st)
    );

    lcw_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_stall(q_stall), .i_job(f_job),
        .i_wp(f_wp), .i_status(f_st), .o_valid(q_valid), .i_pop(pop),
        .o_job(q_job), .o_wp(q_wp), .o_status(q_st)
    );

    lcw_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_pop(pop), .i_job(q_job),
        .i_wp(q_wp), .i_status(q_st), .o_valid, .i_stall, .o_item
    );

endmodule

FILE: rtl/lcw_checker.sv
// ----------------------------------------------------------------------------
// lcw_checker
// port-level checks for the decompressor
// ----------------------------------------------------------------------------
module lcw_checker import lcw_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_valid,
    input logic     i_stall,
    input t_lcw_out o_item
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled beat changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.produced <= 17'h10000)
        else $error("produced out of range");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status == ST_RUN |-> o_item.produced < 17'h10000)
        else $error("running at full length");

endmodule

bind lcw_format80_decompressor_top lcw_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_item
);
